FILE: src/dvc_pkg.sv
package dvc_pkg;

  localparam int unsigned DvcCapacity  = 32;
  localparam int unsigned DvcValueBits = 32;
  localparam int unsigned DataBits     = 32;
  localparam int unsigned CountBits    = 6;
  localparam logic [CountBits-1:0] CountMax = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_REF,
    ST_RD,
    ST_CMP,
    ST_DONE,
    ST_FINISH
  } dvc_state_e;

  typedef struct packed {
    logic load_ref;
    logic cmp_en;
  } dvc_match_ctrl_t;

  typedef struct packed {
    logic                 hit;
    logic [CountBits-1:0] count;
  } dvc_match_stat_t;

endpackage

FILE: src/dvc_if.sv
interface dvc_in_if;
  import dvc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DataBits-1:0] value;
  logic                       last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

interface dvc_out_if;
  import dvc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DataBits-1:0] dup_value;
  logic [CountBits-1:0]       occurrences;
  logic                       last_out;

  modport source (output valid, output dup_value, output occurrences, output last_out,
                  input ready);
  modport sink (input valid, input dup_value, input occurrences, input last_out,
                output ready);
endinterface

FILE: src/dvc_mem.sv
module dvc_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dvc_match.sv
module dvc_match #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                      clk_i,
  input  dvc_pkg::dvc_match_ctrl_t  ctrl_i,
  input  logic [WIDTH-1:0]          rdata_i,
  output logic [WIDTH-1:0]          ref_o,
  output dvc_pkg::dvc_match_stat_t  stat_o
);
  import dvc_pkg::*;

  logic [WIDTH-1:0]     ref_q;
  logic [CountBits-1:0] count_q;
  logic                 hit;

  // One comparator serves every probe of the current row.
  assign hit = ctrl_i.cmp_en && (rdata_i == ref_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_ref) begin
      ref_q   <= rdata_i;
      count_q <= '0;
    end else if (hit && (count_q != CountMax)) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign ref_o        = ref_q;
  assign stat_o.hit   = hit;
  assign stat_o.count = count_q;

endmodule

FILE: src/dvc_seq.sv
module dvc_seq #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned SB       = 32,
  parameter int unsigned AW       = 5,
  parameter int unsigned FW       = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_last_i,
  output logic                              in_ready_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [SB-1:0]                     out_value_o,
  output logic [dvc_pkg::CountBits-1:0]     out_count_o,
  output logic                              out_last_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic [AW-1:0]                     mem_raddr_o,
  output dvc_pkg::dvc_match_ctrl_t          match_ctrl_o,
  input  dvc_pkg::dvc_match_stat_t          match_stat_i,
  input  logic [SB-1:0]                     ref_i
);
  import dvc_pkg::*;

  dvc_state_e state_q, state_d;

  logic [FW-1:0]        fill_q, i_q, j_q;
  logic [CAPACITY-1:0]  counted_q;
  logic                 pend_vld_q;
  logic [SB-1:0]        pend_val_q;
  logic [CountBits-1:0] pend_cnt_q;
  logic                 out_vld_q, out_last_q;
  logic [SB-1:0]        out_val_q;
  logic [CountBits-1:0] out_cnt_q;

  logic accept, not_full, out_free, is_dup, row_end, scan_end;
  logic i_inc, j_set, j_inc, push, emit_final;

  assign accept   = in_valid_i && in_ready_o;
  assign not_full = fill_q < FW'(CAPACITY);
  assign out_free = !out_vld_q || out_ready_i;
  assign is_dup   = match_stat_i.count > CountBits'(1);
  assign row_end  = i_q == fill_q;
  assign scan_end = j_q == fill_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_last_i) state_d = ST_ROW;
      end
      ST_ROW: begin
        if (row_end) state_d = ST_FINISH;
        else if (!counted_q[i_q[AW-1:0]]) state_d = ST_REF;
      end
      ST_REF: state_d = ST_RD;
      ST_RD: begin
        state_d = scan_end ? ST_DONE : ST_CMP;
      end
      ST_CMP: state_d = ST_RD;
      ST_DONE: begin
        if (!is_dup || !pend_vld_q || out_free) state_d = ST_ROW;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o            = 1'b0;
    mem_we_o              = 1'b0;
    match_ctrl_o.load_ref = 1'b0;
    match_ctrl_o.cmp_en   = 1'b0;
    i_inc                 = 1'b0;
    j_set                 = 1'b0;
    j_inc                 = 1'b0;
    push                  = 1'b0;
    emit_final            = 1'b0;
    mem_raddr_o           = j_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we_o   = accept && not_full;
      end
      ST_ROW: begin
        mem_raddr_o = i_q[AW-1:0];
        if (!row_end) begin
          if (counted_q[i_q[AW-1:0]]) i_inc = 1'b1;
          else j_set = 1'b1;
        end
      end
      ST_REF: match_ctrl_o.load_ref = 1'b1;
      ST_RD: ;
      ST_CMP: begin
        match_ctrl_o.cmp_en = 1'b1;
        j_inc               = 1'b1;
      end
      ST_DONE: begin
        if (!is_dup) begin
          i_inc = 1'b1;
        end else if (!pend_vld_q || out_free) begin
          i_inc = 1'b1;
          push  = 1'b1;
        end
      end
      ST_FINISH: emit_final = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      i_q        <= '0;
      j_q        <= '0;
      counted_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we_o) fill_q <= fill_q + 1'b1;
      if (i_inc) i_q <= i_q + 1'b1;
      if (j_set) j_q <= i_q;
      else if (j_inc) j_q <= j_q + 1'b1;
      if (match_stat_i.hit) counted_q[j_q[AW-1:0]] <= 1'b1;
      if (push) pend_vld_q <= 1'b1;
      if (emit_final) begin
        fill_q     <= '0;
        i_q        <= '0;
        counted_q  <= '0;
        pend_vld_q <= 1'b0;
      end
      if ((push && pend_vld_q) || emit_final) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_val_q <= ref_i;
      pend_cnt_q <= match_stat_i.count;
    end
    if (push && pend_vld_q) begin
      out_val_q  <= pend_val_q;
      out_cnt_q  <= pend_cnt_q;
      out_last_q <= 1'b0;
    end else if (emit_final) begin
      out_val_q  <= pend_vld_q ? pend_val_q : '0;
      out_cnt_q  <= pend_vld_q ? pend_cnt_q : '0;
      out_last_q <= 1'b1;
    end
  end

  assign mem_waddr_o = fill_q[AW-1:0];
  assign out_valid_o = out_vld_q;
  assign out_value_o = out_val_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: src/duplicate_value_counter.sv
// Load: one word per cycle, one beat accepted per clock while loading.
// Report: after the last beat the stored words are walked row by row, and a stalled
// report side holds the walk. The single read port of the value memory and the one
// shared comparator bound how fast the walk goes.
// Each unclaimed row is compared word by word from its own entry on; a claimed row is skipped.
// Reset is asynchronous and active low; it clears control state and the claimed flags.
module duplicate_value_counter #(
  parameter int unsigned CAPACITY   = dvc_pkg::DvcCapacity,
  parameter int unsigned VALUE_BITS = dvc_pkg::DvcValueBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvc_in_if.sink     data_i,
  dvc_out_if.source  report_o
);
  import dvc_pkg::*;

  // Only the low VALUE_BITS bits of a word take part in the comparison, and the
  // data field itself is DataBits wide, so the memory holds the narrower of the two.
  localparam int unsigned SB = (VALUE_BITS < DataBits) ? VALUE_BITS : DataBits;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [SB-1:0]        mem_rdata;
  logic [SB-1:0]        ref_value;
  logic [SB-1:0]        out_value;
  dvc_match_ctrl_t      match_ctrl;
  dvc_match_stat_t      match_stat;

  // Value memory: written during the load, then read once per cycle in the report.
  // Only entries below the fill level are ever read, so it needs no reset.
  dvc_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (SB),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_i.value[SB-1:0]),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared compare and count unit: holds the reference word of the current row
  // and counts the stored words equal to it, saturating at the field maximum.
  dvc_match #(
    .WIDTH (SB)
  ) u_match (
    .clk_i   (clk_i),
    .ctrl_i  (match_ctrl),
    .rdata_i (mem_rdata),
    .ref_o   (ref_value),
    .stat_o  (match_stat)
  );

  // Sequencer: walks the rows in order of first appearance, scans each unclaimed
  // row against all later words, and keeps one finished report pending so that
  // the final one can be marked when the walk ends.
  dvc_seq #(
    .CAPACITY (CAPACITY),
    .SB       (SB),
    .AW       (AW),
    .FW       (FW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (data_i.valid),
    .in_last_i    (data_i.last_in),
    .in_ready_o   (data_i.ready),
    .out_ready_i  (report_o.ready),
    .out_valid_o  (report_o.valid),
    .out_value_o  (out_value),
    .out_count_o  (report_o.occurrences),
    .out_last_o   (report_o.last_out),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_raddr_o  (mem_raddr),
    .match_ctrl_o (match_ctrl),
    .match_stat_i (match_stat),
    .ref_i        (ref_value)
  );

  assign report_o.dup_value = DataBits'(out_value);

  // The comparator only runs while the input side is closed.
  a_no_cmp_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_i.ready |-> !match_ctrl.cmp_en)
    else $error("compare active while accepting input");

  // The memory is only written by an accepted beat.
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (data_i.valid && data_i.ready))
    else $error("memory write without an accepted beat");

  // A report that is not the final one always carries a real duplicate.
  a_mid_report_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (report_o.valid && !report_o.last_out) |-> (report_o.occurrences > CountBits'(1)))
    else $error("non-final report without a duplicate count");

  // The empty report carries a zero value.
  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (report_o.valid && (report_o.occurrences == '0)) |->
      (report_o.last_out && (report_o.dup_value == '0)))
    else $error("malformed empty report");

endmodule

FILE: test/dvc_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the stored set and predicts the
// duplicate reports that each closing beat should produce.
module dvc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dvc_in_if           data_i,
  dvc_out_if          report_i,
  output int unsigned mismatches_o,
  output int unsigned awaited_o
);
  import dvc_pkg::*;

  typedef struct packed {
    logic signed [DataBits-1:0] dup_value;
    logic [CountBits-1:0]       occurrences;
    logic                       last_out;
  } dup_report_t;

  logic signed [DataBits-1:0] held_words [DvcCapacity];
  int unsigned                fill_level;
  dup_report_t                reports_due [$];
  int unsigned                error_count = 0;

  // Counts every distinct held word and queues one report per repeated value,
  // in order of first appearance, or the empty report when nothing repeats.
  task automatic tally_repeats();
    logic [CountBits-1:0] tally [DvcCapacity];
    bit                   claimed [DvcCapacity];
    int                   final_row;
    dup_report_t          rep;
    final_row = -1;
    for (int i = 0; i < DvcCapacity; i++) begin
      tally[i]   = '0;
      claimed[i] = 1'b0;
    end
    for (int i = 0; i < fill_level; i++) begin
      if (claimed[i]) continue;
      for (int j = 0; j < fill_level; j++) begin
        if (held_words[i] === held_words[j]) begin
          if (tally[i] < CountMax) tally[i]++;
          claimed[j] = 1'b1;
        end
      end
      if (tally[i] > 1) final_row = i;
    end
    for (int i = 0; i < fill_level; i++) begin
      if (tally[i] > 1) begin
        rep.dup_value   = held_words[i];
        rep.occurrences = tally[i];
        rep.last_out    = (i == final_row);
        reports_due.push_back(rep);
      end
    end
    if (final_row < 0) begin
      rep.dup_value   = '0;
      rep.occurrences = '0;
      rep.last_out    = 1'b1;
      reports_due.push_back(rep);
    end
    fill_level = 0;
  endtask

  task automatic check_report();
    dup_report_t want;
    if (reports_due.size() == 0) begin
      $display("%0t: unexpected report beat, dup_value %0d occurrences %0d last_out %0b",
               $time, report_i.dup_value, report_i.occurrences, report_i.last_out);
      error_count++;
    end else begin
      want = reports_due.pop_front();
      if (report_i.dup_value !== want.dup_value) begin
        $display("%0t: dup_value expected %0d actual %0d",
                 $time, want.dup_value, report_i.dup_value);
        error_count++;
      end
      if (report_i.occurrences !== want.occurrences) begin
        $display("%0t: occurrences expected %0d actual %0d",
                 $time, want.occurrences, report_i.occurrences);
        error_count++;
      end
      if (report_i.last_out !== want.last_out) begin
        $display("%0t: last_out expected %0b actual %0b",
                 $time, want.last_out, report_i.last_out);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_level = 0;
      reports_due.delete();
      awaited_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (report_i.valid && report_i.ready) check_report();
      if (data_i.valid && data_i.ready) begin
        // Words beyond capacity are dropped, but a marked one still closes the set.
        if (fill_level < DvcCapacity) begin
          held_words[fill_level] = data_i.value;
          fill_level++;
        end
        if (data_i.last_in) tally_repeats();
      end
      awaited_o    <= reports_due.size();
      mismatches_o <= error_count;
    end
  end

endmodule

FILE: test/duplicate_value_counter_tb.sv
`timescale 1ns / 1ps

// Top of the bench for the duplicate value counter. It only produces traffic:
// sets of words on the input channel and a randomly stalling ready on the
// report channel. The checker instance beside the block does all prediction
// and comparison and hands back its mismatch count for the verdict.
module duplicate_value_counter_tb;
  import dvc_pkg::*;

  // Number of counted input beats in the random part. Words dropped by a full
  // store do not count toward it.
  localparam int unsigned ItemTarget  = 230;
  // Percentage of cycles in which either side holds off.
  localparam int unsigned IdlePercent = 35;
  // Sets within this window run with no idling on either side.
  localparam int unsigned SteadyFirst = 10;
  localparam int unsigned SteadyLast  = 18;
  // Quiet cycles after the last expected report, to catch stray beats.
  localparam int unsigned DrainCycles = 64;
  // The slowest report is that of a full store; the random part has only a handful
  // of those, so the timeout leaves a wide margin.
  localparam int unsigned TimeoutNs   = 5_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned set_index;

  // Words of the set that send_set pushes out next, the last one marked.
  logic signed [DataBits-1:0] set_words [$];

  dvc_in_if  data_if ();
  dvc_out_if report_if ();

  duplicate_value_counter i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (data_if),
    .report_o (report_if)
  );

  dvc_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_i       (data_if),
    .report_i     (report_if),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The hard stop. Reaching it means the block hung or lost reports.
  initial begin
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

  // The report side stalls at random, except inside the steady window.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      report_if.ready <= 1'b0;
    end else begin
      report_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Sends the words in set_words as one set. Before each beat the sender may
  // idle for a few cycles; valid stays high from beat to beat otherwise, and
  // each beat is held until the block takes it.
  task automatic send_set();
    steady <= (set_index >= SteadyFirst) && (set_index < SteadyLast);
    for (int k = 0; k < set_words.size(); k++) begin
      while (!steady && ($urandom_range(99) < IdlePercent)) begin
        data_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      data_if.valid   <= 1'b1;
      data_if.value   <= set_words[k];
      data_if.last_in <= (k == set_words.size() - 1);
      @(posedge clk_i);
      while (!data_if.ready) @(posedge clk_i);
    end
    set_index++;
  endtask

  initial begin
    logic signed [DataBits-1:0] pool [6];
    int unsigned                counted;
    int unsigned                pick;
    int unsigned                set_len;
    int unsigned                pool_len;

    rst_ni          = 1'b0;
    steady          = 1'b0;
    set_index       = 0;
    data_if.valid   <= 1'b0;
    data_if.value   <= '0;
    data_if.last_in <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets. A lone word closes a set with nothing to repeat, so the
    // block must give the empty report.
    set_words = '{32'h8000_0000};
    send_set();
    // The most negative word twice: one report with a count of two.
    set_words = '{32'h8000_0000, 32'h8000_0000};
    send_set();
    // Mixed extremes. The reports must come in order of first appearance, the
    // largest positive word before all-ones, and the alternating patterns are
    // singletons that must not show up.
    set_words = '{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    send_set();
    // All distinct words of several entries: again the empty report.
    set_words = '{32'd1, 32'd2, 32'd4, 32'd8, 32'd16};
    send_set();
    // Words that differ in a single bit must not be merged.
    set_words = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
                  32'h0001_0000, 32'h0000_0001};
    send_set();

    // Random sets. Most draw their words from a small pool so repeats are
    // common; a few overrun the store to check that extra words are dropped
    // while the marked one still closes the set; the rest are plain noise.
    counted = 0;
    while (counted < ItemTarget) begin
      pick = $urandom_range(99);
      set_words.delete();
      if (pick < 8) begin
        set_len  = $urandom_range(DvcCapacity + 4, DvcCapacity);
        pool_len = $urandom_range(4, 1);
      end else if (pick < 85) begin
        set_len  = $urandom_range(12, 1);
        pool_len = $urandom_range(6, 1);
      end else begin
        set_len  = $urandom_range(10, 1);
        pool_len = 0;
      end
      for (int p = 0; p < pool_len; p++) pool[p] = $urandom;
      for (int k = 0; k < set_len; k++) begin
        if (pool_len == 0) begin
          set_words.push_back($urandom);
        end else begin
          set_words.push_back(pool[$urandom_range(pool_len - 1, 0)]);
        end
      end
      send_set();
      counted += (set_len < DvcCapacity) ? set_len : DvcCapacity;
    end

    // Drop valid, then wait for the next edge so the checker's count of awaited reports
    // already includes the final set before it is polled.
    data_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
